>>> sv/tphb_pkg.sv
// Shared types, constants and helpers for the TCP probe header builder.
package tphb_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_TOTAL_LENGTH = 2'd0;
  localparam logic [1:0] CFG_IP_IDENT     = 2'd1;
  localparam logic [1:0] CFG_TIME_TO_LIVE = 2'd2;
  localparam logic [1:0] CFG_WINDOW_SIZE  = 2'd3;

  // Configuration reset values
  localparam logic [15:0] RST_TOTAL_LENGTH = 16'd40;
  localparam logic [15:0] RST_IP_IDENT     = 16'd54321;
  localparam logic [7:0]  RST_TIME_TO_LIVE = 8'd64;
  localparam logic [15:0] RST_WINDOW_SIZE  = 16'd65535;

  // Fixed header contents
  localparam logic [7:0]  IP_VER_IHL   = 8'h45;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [3:0]  TCP_DOFF     = 4'd5;
  localparam logic [15:0] IP_HDR_BYTES = 16'd20;
  localparam logic [3:0]  LAST_WORD    = 4'd9;

  // Probe kinds
  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_SYN  = 3'd1;
  localparam logic [2:0] KIND_FIN  = 3'd2;
  localparam logic [2:0] KIND_ACK  = 3'd3;
  localparam logic [2:0] KIND_XMAS = 3'd4;

  // TCP flag bits
  localparam logic [7:0] TCP_FIN = 8'h01;
  localparam logic [7:0] TCP_SYN = 8'h02;
  localparam logic [7:0] TCP_PSH = 8'h08;
  localparam logic [7:0] TCP_ACK = 8'h10;
  localparam logic [7:0] TCP_URG = 8'h20;

  typedef struct packed {
    logic [15:0] total_length;
    logic [15:0] ip_ident;
    logic [7:0]  time_to_live;
    logic [15:0] window_size;
  } cfg_t;

  // One classified request with both checksums done
  typedef struct packed {
    logic [31:0] ip_src;
    logic [31:0] ip_dst;
    logic [15:0] tcp_sport;
    logic [15:0] tcp_dport;
    logic [7:0]  flags;
    logic [15:0] ip_csum;
    logic [15:0] tcp_csum;
  } hdr_entry_t;

  // Map a probe kind to its TCP flag byte
  function automatic logic [7:0] kind_flags(input logic [2:0] kind);
    logic [7:0] f;
    case (kind)
      KIND_SYN:  f = TCP_SYN;
      KIND_FIN:  f = TCP_FIN;
      KIND_ACK:  f = TCP_ACK;
      KIND_XMAS: f = TCP_FIN | TCP_PSH | TCP_URG;
      default:   f = 8'h00;
    endcase
    return f;
  endfunction

  // Fold a one's-complement sum to 16 bits and invert it
  function automatic logic [15:0] fold_invert(input logic [19:0] acc);
    logic [16:0] f1;
    logic [15:0] f2;
    f1 = {13'd0, acc[19:16]} + {1'b0, acc[15:0]};
    f2 = f1[15:0] + {15'd0, f1[16]};
    return ~f2;
  endfunction

endpackage

>>> sv/tcp_probe_header_builder_unit.sv
// Top level of the IPv4+TCP probe header builder.
//
// Input channel (push/full): one probe request per item: addresses, ports and
// probe kind. Result channel (empty/pop): ten 32-bit header words per request
// in network order, with word_index 0..9 and last set on word 9.
// Configuration channel (valid/ready, always ready): total length, IP ident,
// TTL and TCP window; write only while no request is in flight.
//
// Path: a request passes two front stages (capture with address sum, then
// checksum sums), is folded into the queue and is loaded from the queue into
// the result register, from which word 0 is shown.
// Throughput: one result word per cycle while the receiver keeps popping; the
// word sequencer sets that rate. The front end and the QUEUE_DEPTH-entry
// queue take further requests while words are still going out.
//
// Reset clears the pipeline, queue and result valid state and loads the
// register defaults. When the receiver holds pop low, the current word stays
// put, the queue fills, and full rises once the front stages are occupied too.
module tcp_probe_header_builder_unit
  import tphb_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_ip_src,
  input  logic [31:0] in_ip_dst,
  input  logic [15:0] in_tcp_sport,
  input  logic [15:0] in_tcp_dport,
  input  logic [2:0]  in_func,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_header_word,
  output logic [3:0]  out_word_index,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t       cfg_r, cfg_nxt;
  logic       q_push, q_full, q_pop, q_nonempty;
  hdr_entry_t q_wr_entry, q_rd_entry;

  assign cfg_ready = 1'b1;

  // Decode configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TOTAL_LENGTH: cfg_nxt.total_length = cfg_data;
        CFG_IP_IDENT:     cfg_nxt.ip_ident     = cfg_data;
        CFG_TIME_TO_LIVE: cfg_nxt.time_to_live = cfg_data[7:0];
        CFG_WINDOW_SIZE:  cfg_nxt.window_size  = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.total_length <= RST_TOTAL_LENGTH;
      cfg_r.ip_ident     <= RST_IP_IDENT;
      cfg_r.time_to_live <= RST_TIME_TO_LIVE;
      cfg_r.window_size  <= RST_WINDOW_SIZE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tphb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_ip_src    (in_ip_src),
    .in_ip_dst    (in_ip_dst),
    .in_tcp_sport (in_tcp_sport),
    .in_tcp_dport (in_tcp_dport),
    .in_func      (in_func),
    .cfg          (cfg_r),
    .q_push       (q_push),
    .q_full       (q_full),
    .q_entry      (q_wr_entry)
  );

  tphb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .rd_entry (q_rd_entry)
  );

  tphb_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_nonempty      (q_nonempty),
    .q_entry         (q_rd_entry),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_header_word (out_header_word),
    .out_word_index  (out_word_index),
    .out_last        (out_last)
  );

endmodule

>>> sv/tphb_front.sv
// Front end: accepts requests, classifies the probe kind and computes both checksums.
module tphb_front
  import tphb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_ip_src,
  input  logic [31:0] in_ip_dst,
  input  logic [15:0] in_tcp_sport,
  input  logic [15:0] in_tcp_dport,
  input  logic [2:0]  in_func,
  input  cfg_t        cfg,
  output logic        q_push,
  input  logic        q_full,
  output hdr_entry_t  q_entry
);

  // Stage A: captured request plus the address half-word sum
  logic        a_vld_r, a_vld_nxt;
  logic [31:0] a_src_r, a_dst_r;
  logic [15:0] a_sport_r, a_dport_r;
  logic [7:0]  a_flags_r;
  logic [17:0] a_asum_r;

  // Stage B: raw checksum sums
  logic        b_vld_r, b_vld_nxt;
  logic [31:0] b_src_r, b_dst_r;
  logic [15:0] b_sport_r, b_dport_r;
  logic [7:0]  b_flags_r;
  logic [19:0] b_ipsum_r, b_tcpsum_r;

  logic        accept, a_adv, b_adv;
  logic [15:0] tcp_len;
  logic [19:0] ipsum, tcpsum;

  // Handshake and stall chain
  assign q_push  = b_vld_r && !q_full;
  assign b_adv   = !b_vld_r || q_push;
  assign a_adv   = !a_vld_r || b_adv;
  assign in_full = !a_adv;
  assign accept  = in_push && !in_full;

  assign a_vld_nxt = a_adv ? accept : a_vld_r;
  assign b_vld_nxt = b_adv ? a_vld_r : b_vld_r;

  // Sum the fixed, config and TCP port/flag terms onto the shared address sum
  assign tcp_len = cfg.total_length - IP_HDR_BYTES;
  assign ipsum  = {2'd0, a_asum_r} + {4'd0, IP_VER_IHL, 8'h00} + {4'd0, cfg.total_length}
                + {4'd0, cfg.ip_ident} + {4'd0, cfg.time_to_live, PROTO_TCP};
  assign tcpsum = {2'd0, a_asum_r} + {12'd0, PROTO_TCP} + {4'd0, tcp_len}
                + {4'd0, a_sport_r} + {4'd0, a_dport_r}
                + {4'd0, TCP_DOFF, 4'd0, a_flags_r} + {4'd0, cfg.window_size};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
      b_vld_r <= b_vld_nxt;
    end
  end

  // Capture request and classify
  always_ff @(posedge clk) begin
    if (a_adv && accept) begin
      a_src_r   <= in_ip_src;
      a_dst_r   <= in_ip_dst;
      a_sport_r <= in_tcp_sport;
      a_dport_r <= in_tcp_dport;
      a_flags_r <= kind_flags(in_func);
      a_asum_r  <= {2'd0, in_ip_src[31:16]} + {2'd0, in_ip_src[15:0]}
                 + {2'd0, in_ip_dst[31:16]} + {2'd0, in_ip_dst[15:0]};
    end
  end

  // Advance into the sum stage
  always_ff @(posedge clk) begin
    if (b_adv && a_vld_r) begin
      b_src_r    <= a_src_r;
      b_dst_r    <= a_dst_r;
      b_sport_r  <= a_sport_r;
      b_dport_r  <= a_dport_r;
      b_flags_r  <= a_flags_r;
      b_ipsum_r  <= ipsum;
      b_tcpsum_r <= tcpsum;
    end
  end

  // Fold the sums on the way into the queue
  always_comb begin
    q_entry.ip_src    = b_src_r;
    q_entry.ip_dst    = b_dst_r;
    q_entry.tcp_sport = b_sport_r;
    q_entry.tcp_dport = b_dport_r;
    q_entry.flags     = b_flags_r;
    q_entry.ip_csum   = fold_invert(b_ipsum_r);
    q_entry.tcp_csum  = fold_invert(b_tcpsum_r);
  end

endmodule

>>> sv/tphb_queue.sv
// Short request queue between the front end and the word sequencer.
module tphb_queue
  import tphb_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  hdr_entry_t wr_entry,
  output logic       full,
  input  logic       pop,
  output logic       nonempty,
  output hdr_entry_t rd_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  hdr_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_FULL);
  assign nonempty = (cnt_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign rd_entry = mem_r[rd_ptr_r];

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

>>> sv/tphb_back.sv
// Back end: walks the ten header words of the queue head into the result register.
module tphb_back
  import tphb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_nonempty,
  input  hdr_entry_t  q_entry,
  output logic        q_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_header_word,
  output logic [3:0]  out_word_index,
  output logic        out_last
);

  logic [3:0]  cnt_r, cnt_nxt;
  logic        out_vld_r, out_vld_nxt;
  logic [31:0] word_r;
  logic [3:0]  idx_r;
  logic        last_r;
  logic        load, is_last;
  logic [31:0] word;

  assign out_empty       = !out_vld_r;
  assign out_header_word = word_r;
  assign out_word_index  = idx_r;
  assign out_last        = last_r;

  assign load    = q_nonempty && (!out_vld_r || out_pop);
  assign is_last = (cnt_r == LAST_WORD);
  assign q_pop   = load && is_last;

  // Select the header word for the current position
  always_comb begin
    case (cnt_r)
      4'd0:    word = {IP_VER_IHL, 8'h00, cfg.total_length};
      4'd1:    word = {cfg.ip_ident, 16'h0000};
      4'd2:    word = {cfg.time_to_live, PROTO_TCP, q_entry.ip_csum};
      4'd3:    word = q_entry.ip_src;
      4'd4:    word = q_entry.ip_dst;
      4'd5:    word = {q_entry.tcp_sport, q_entry.tcp_dport};
      4'd8:    word = {TCP_DOFF, 4'd0, q_entry.flags, cfg.window_size};
      4'd9:    word = {q_entry.tcp_csum, 16'h0000};
      default: word = 32'd0;
    endcase
  end

  // Advance the word counter and hold the result while stalled
  always_comb begin
    cnt_nxt     = cnt_r;
    out_vld_nxt = out_vld_r;
    if (load) begin
      cnt_nxt     = is_last ? 4'd0 : cnt_r + 4'd1;
      out_vld_nxt = 1'b1;
    end else if (out_pop) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= 4'd0;
      out_vld_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= word;
      idx_r  <= cnt_r;
      last_r <= is_last;
    end
  end

endmodule

>>> test/tcp_probe_header_builder_unit_tb.sv
// Self-checking testbench for the IPv4+TCP probe header builder.
module tcp_probe_header_builder_unit_tb
  import tphb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 32;
  localparam int HOLD_CYCLES  = 200;
  localparam int SETTLE       = 8;

  typedef logic [9:0][31:0] header_t;

  // One expected header word
  typedef struct packed {
    logic [31:0] word;
    logic [3:0]  index;
    logic        last;
  } header_word_t;

  // One directed probe; golden words are used only when typed is set
  typedef struct packed {
    logic [31:0] ip_src;
    logic [31:0] ip_dst;
    logic [15:0] tcp_sport;
    logic [15:0] tcp_dport;
    logic [2:0]  func;
    logic        typed;
    header_t     golden;
  } probe_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [31:0] in_ip_src = '0;
  logic [31:0] in_ip_dst = '0;
  logic [15:0] in_tcp_sport = '0;
  logic [15:0] in_tcp_dport = '0;
  logic [2:0]  in_func = KIND_NONE;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [31:0] out_header_word;
  logic [3:0]  out_word_index;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_TOTAL_LENGTH;
  logic [15:0] cfg_data = '0;

  header_word_t header_words_due[$];
  cfg_t         shadow_cfg;
  int           error_count = 0;
  bit           steady = 1'b0;
  bit           stall_request = 1'b0;
  probe_row_t   probe_table[12];

  tcp_probe_header_builder_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_ip_src(in_ip_src), .in_ip_dst(in_ip_dst),
    .in_tcp_sport(in_tcp_sport), .in_tcp_dport(in_tcp_dport), .in_func(in_func),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_header_word(out_header_word), .out_word_index(out_word_index),
    .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Fold a 32-bit one's-complement accumulator to 16 bits and invert
  function automatic logic [15:0] csum16(input logic [31:0] acc);
    logic [31:0] s;
    s = acc[31:16] + acc[15:0];
    s = s + s[31:16];
    return ~s[15:0];
  endfunction

  // Build the ten header words for one probe under a given register setting
  function automatic header_t build_probe_header(input cfg_t c,
      input logic [31:0] src, input logic [31:0] dst,
      input logic [15:0] sport, input logic [15:0] dport, input logic [2:0] kind);
    header_t     w;
    logic [7:0]  flags;
    logic [15:0] seg_len;
    logic [31:0] acc;
    case (kind)
      KIND_SYN:  flags = TCP_SYN;
      KIND_FIN:  flags = TCP_FIN;
      KIND_ACK:  flags = TCP_ACK;
      KIND_XMAS: flags = TCP_FIN | TCP_PSH | TCP_URG;
      default:   flags = 8'h00;
    endcase
    // TCP length wraps when total length is below the IP header size
    seg_len = c.total_length - IP_HDR_BYTES;
    w = '0;
    w[0] = {IP_VER_IHL, 8'h00, c.total_length};
    w[1] = {c.ip_ident, 16'h0000};
    w[2] = {c.time_to_live, PROTO_TCP, 16'h0000};
    w[3] = src;
    w[4] = dst;
    w[5] = {sport, dport};
    w[8] = {TCP_DOFF, 4'h0, flags, c.window_size};
    acc = '0;
    for (int i = 0; i < 5; i++) acc = acc + w[i][31:16] + w[i][15:0];
    w[2][15:0] = csum16(acc);
    // Pseudo-header, then the TCP header words
    acc = src[31:16] + src[15:0] + dst[31:16] + dst[15:0] + PROTO_TCP + seg_len;
    for (int i = 5; i < 10; i++) acc = acc + w[i][31:16] + w[i][15:0];
    w[9][31:16] = csum16(acc);
    return w;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  function automatic probe_row_t make_row(input logic [31:0] src,
      input logic [31:0] dst, input logic [15:0] sport, input logic [15:0] dport,
      input logic [2:0] func, input logic typed, input header_t golden);
    probe_row_t r;
    r.ip_src = src;
    r.ip_dst = dst;
    r.tcp_sport = sport;
    r.tcp_dport = dport;
    r.func = func;
    r.typed = typed;
    r.golden = golden;
    return r;
  endfunction

  // Offer one probe, hold until accepted, then queue its header words
  task automatic offer_probe(input logic [31:0] src, input logic [31:0] dst,
      input logic [15:0] sport, input logic [15:0] dport, input logic [2:0] func,
      input logic typed, input header_t golden);
    header_t      words;
    header_word_t hw;
    int           gap;
    in_push      <= 1'b1;
    in_ip_src    <= src;
    in_ip_dst    <= dst;
    in_tcp_sport <= sport;
    in_tcp_dport <= dport;
    in_func      <= func;
    do @(posedge clk); while (in_full);
    words = typed ? golden : build_probe_header(shadow_cfg, src, dst, sport, dport, func);
    for (int i = 0; i < 10; i++) begin
      hw.word  = words[i];
      hw.index = 4'(i);
      hw.last  = (4'(i) == LAST_WORD);
      header_words_due.push_back(hw);
    end
    gap = (steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Write one register and track it; valid is lowered by the caller
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TOTAL_LENGTH: shadow_cfg.total_length = data;
      CFG_IP_IDENT:     shadow_cfg.ip_ident = data;
      CFG_TIME_TO_LIVE: shadow_cfg.time_to_live = data[7:0];
      CFG_WINDOW_SIZE:  shadow_cfg.window_size = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] tlen, input logic [15:0] ident,
      input logic [15:0] ttl, input logic [15:0] win);
    write_reg(CFG_TOTAL_LENGTH, tlen);
    write_reg(CFG_IP_IDENT, ident);
    write_reg(CFG_TIME_TO_LIVE, ttl);
    write_reg(CFG_WINDOW_SIZE, win);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering and wait until every header word has come out
  task automatic drain_headers();
    in_push <= 1'b0;
    while (header_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Result side: random pop with idle gaps, one long hold-off on request
  initial begin : result_side
    int           idle_left;
    int           hold_left;
    bit           stall_taken;
    bit           pop_next;
    header_word_t hw;
    idle_left = 0;
    hold_left = 0;
    stall_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        if (header_words_due.size() == 0) begin
          $error("header_word: none expected, actual %h", out_header_word);
          error_count++;
        end else begin
          hw = header_words_due.pop_front();
          if (out_header_word !== hw.word) begin
            $error("header_word: expected %h, actual %h", hw.word, out_header_word);
            error_count++;
          end
          if (out_word_index !== hw.index) begin
            $error("word_index: expected %0d, actual %0d", hw.index, out_word_index);
            error_count++;
          end
          if (out_last !== hw.last) begin
            $error("last: expected %0b, actual %0b", hw.last, out_last);
            error_count++;
          end
        end
      end
      if (stall_request && !stall_taken) begin
        hold_left = HOLD_CYCLES;
        stall_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop_next = 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        pop_next = 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        idle_left = pick_gap() - 1;
        pop_next = 1'b0;
      end else begin
        pop_next = 1'b1;
      end
      out_pop <= pop_next;
    end
  end

  initial begin : stimulus
    logic [15:0] tlen, ident, ttl, win;
    logic [31:0] src, dst;
    // Reset defaults, all zero probe: word 9 first
    probe_table[0] = make_row(32'h0, 32'h0, 16'h0, 16'h0, KIND_NONE, 1'b1,
      {32'hAFE50000, 32'h5000FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
       32'h4006A69F, 32'hD4310000, 32'h45000028});
    // Reset defaults, all ones with an unknown kind: no flags
    probe_table[1] = make_row(32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 3'd7,
      1'b1,
      {32'hAFE50000, 32'h5000FFFF, 32'h0, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF,
       32'hFFFFFFFF, 32'h4006A69F, 32'hD4310000, 32'h45000028});
    probe_table[2]  = make_row(32'hC0A80001, 32'h0A000002, 16'd12345, 16'd80,
                               KIND_SYN, 1'b0, '0);
    probe_table[3]  = make_row(32'hC0A80001, 32'h0A000002, 16'd40000, 16'd443,
                               KIND_FIN, 1'b0, '0);
    probe_table[4]  = make_row(32'h7F000001, 32'h08080808, 16'd1024, 16'd22,
                               KIND_ACK, 1'b0, '0);
    probe_table[5]  = make_row(32'hAC100A0B, 32'hC0000201, 16'd5555, 16'd8080,
                               KIND_XMAS, 1'b0, '0);
    probe_table[6]  = make_row(32'h01020304, 32'h05060708, 16'd1, 16'd2,
                               3'd5, 1'b0, '0);
    probe_table[7]  = make_row(32'h0A0A0A0A, 32'hFEFEFEFE, 16'hFFFE, 16'h0001,
                               3'd6, 1'b0, '0);
    probe_table[8]  = make_row(32'hFFFFFFFF, 32'h0, 16'hFFFF, 16'h0, KIND_SYN,
                               1'b0, '0);
    probe_table[9]  = make_row(32'h0, 32'hFFFFFFFF, 16'h0, 16'hFFFF, KIND_ACK,
                               1'b0, '0);
    probe_table[10] = make_row(32'h80000000, 32'h00000001, 16'h8000, 16'h0001,
                               KIND_XMAS, 1'b0, '0);
    probe_table[11] = make_row(32'hAAAAAAAA, 32'h55555555, 16'hA5A5, 16'h5A5A,
                               KIND_FIN, 1'b0, '0);

    shadow_cfg.total_length = RST_TOTAL_LENGTH;
    shadow_cfg.ip_ident     = RST_IP_IDENT;
    shadow_cfg.time_to_live = RST_TIME_TO_LIVE;
    shadow_cfg.window_size  = RST_WINDOW_SIZE;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed probes under reset register values
    foreach (probe_table[i])
      offer_probe(probe_table[i].ip_src, probe_table[i].ip_dst,
                  probe_table[i].tcp_sport, probe_table[i].tcp_dport,
                  probe_table[i].func, probe_table[i].typed, probe_table[i].golden);
    drain_headers();

    // Register settings: extremes and short lengths first, then random
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin tlen = 16'hFFFF; ident = 16'h0000; ttl = 16'hFFFF; win = 16'h0000; end
        1: begin tlen = 16'h0000; ident = 16'hFFFF; ttl = 16'h0000; win = 16'hFFFF; end
        2: begin tlen = 16'd19;   ident = 16'h0001; ttl = 16'h0001; win = 16'h0001; end
        3: begin tlen = 16'd20;   ident = 16'h8000; ttl = 16'hFF80; win = 16'h8000; end
        4: begin tlen = 16'd40;   ident = 16'd54321; ttl = 16'd64; win = 16'hFFFF; end
        default: begin
          tlen  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(40, 1500));
          ident = 16'($urandom);
          ttl   = 16'($urandom);
          win   = 16'($urandom);
        end
      endcase
      set_config(tlen, ident, ttl, win);
      steady = (p == 1);
      // Back-pressure: the result side holds off while probes keep coming
      if (p == 2) stall_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 7))
          0: src = 32'h0;
          1: src = 32'hFFFFFFFF;
          default: src = $urandom;
        endcase
        case ($urandom_range(0, 7))
          0: dst = 32'h0;
          1: dst = 32'hFFFFFFFF;
          default: dst = $urandom;
        endcase
        offer_probe(src, dst, 16'($urandom), 16'($urandom), 3'($urandom_range(0, 7)),
                    1'b0, '0);
      end
      drain_headers();
    end

    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
